// File: rtl/core/rcs_pkg.sv
// ----------------------------------------------------------------------------
// rcs_pkg
// Shared widths, limits, register codes and queue entry type for the ramped
// crossfade selector.
// ----------------------------------------------------------------------------
`default_nettype none

package rcs_pkg;

  // Field widths
  localparam int SampleW    = 24;
  localparam int NumSamples = 8;
  localparam int MaskW      = 8;
  localparam int SelW       = 4;
  localparam int CountW     = 4;
  localparam int StepW      = 22;
  localparam int PosW       = 19;
  localparam int FracW      = 16;
  localparam int IdxW       = PosW - FracW;
  localparam int CfgAddrW   = 2;

  // Count limit: the lower of the supported input count and the sample fields
  localparam int MaxInputs  = 8;
  localparam int EffLim     = (MaxInputs < NumSamples) ? MaxInputs : NumSamples;
  localparam int PosMax     = (EffLim - 1) * (1 << FracW);

  // Register reset values
  localparam int CountReset = 2;
  localparam int StepReset  = 68;

  // Queue between front and back
  localparam int QueueDepth = 2;

  // Configuration register codes
  typedef enum logic [CfgAddrW-1:0] {
    CfgInputCount = 2'd0,
    CfgRampStep   = 2'd1
  } cfg_addr_e;

  // One mix job: picked samples, their weights and the position to report
  typedef struct packed {
    logic signed [SampleW-1:0] sample_a;
    logic signed [SampleW-1:0] sample_b;
    logic [FracW:0]            weight_a;
    logic [FracW-1:0]          weight_b;
    logic [PosW-1:0]           position;
  } mix_job_t;

endpackage

`default_nettype wire

// File: rtl/core/rcs_if.sv
// ----------------------------------------------------------------------------
// rcs_if
// Valid/ready channels of the ramped crossfade selector: input items, result
// items and configuration writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface rcs_in_if;
  logic              valid;
  logic              ready;
  logic signed [23:0] sample_0;
  logic signed [23:0] sample_1;
  logic signed [23:0] sample_2;
  logic signed [23:0] sample_3;
  logic signed [23:0] sample_4;
  logic signed [23:0] sample_5;
  logic signed [23:0] sample_6;
  logic signed [23:0] sample_7;
  logic [7:0]         present_mask;
  logic [3:0]         target_input;
  logic               frame_start;

  modport source (
    output valid, sample_0, sample_1, sample_2, sample_3, sample_4, sample_5,
           sample_6, sample_7, present_mask, target_input, frame_start,
    input  ready
  );
  modport sink (
    input  valid, sample_0, sample_1, sample_2, sample_3, sample_4, sample_5,
           sample_6, sample_7, present_mask, target_input, frame_start,
    output ready
  );
endinterface

interface rcs_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] mixed_sample;
  logic [18:0]        position;

  modport source (output valid, mixed_sample, position, input ready);
  modport sink (input valid, mixed_sample, position, output ready);
endinterface

interface rcs_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  addr;
  logic [21:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/rcs_front.sv
// ----------------------------------------------------------------------------
// rcs_front
// Accepts items, holds the config registers and the fade position, ramps the
// position on frame start and picks the two weighted samples for the back.
// ----------------------------------------------------------------------------
`default_nettype none

module rcs_front (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  rcs_in_if.sink           in_i,
  rcs_cfg_if.sink          cfg_i,
  input  wire logic        full_i,
  output logic             push_o,
  output rcs_pkg::mix_job_t job_o
);

  logic [rcs_pkg::CountW-1:0]  n_inputs_q;
  logic [rcs_pkg::StepW-1:0]   glide_step_q;
  logic [rcs_pkg::PosW-1:0]    pos_q, pos_d;

  logic                        acc;
  logic signed [rcs_pkg::SampleW-1:0] smp [rcs_pkg::NumSamples];
  logic [rcs_pkg::CountW-1:0]  cnt;
  logic [rcs_pkg::SelW-1:0]    sel;
  logic [rcs_pkg::IdxW-1:0]    sel_m1;
  logic [rcs_pkg::PosW-1:0]    target;
  logic [rcs_pkg::StepW:0]     pos_up;
  logic [rcs_pkg::PosW-1:0]    diff;
  logic [rcs_pkg::PosW-1:0]    pos_ramp;
  logic [rcs_pkg::IdxW-1:0]    idx_a, idx_b;
  logic [rcs_pkg::IdxW:0]      idx_b_wide;
  logic [rcs_pkg::FracW-1:0]   frac;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = !full_i;
  assign acc         = in_i.valid && !full_i;
  assign push_o      = acc;

  assign smp[0] = in_i.sample_0;
  assign smp[1] = in_i.sample_1;
  assign smp[2] = in_i.sample_2;
  assign smp[3] = in_i.sample_3;
  assign smp[4] = in_i.sample_4;
  assign smp[5] = in_i.sample_5;
  assign smp[6] = in_i.sample_6;
  assign smp[7] = in_i.sample_7;

  // Effective count and clamped target
  always_comb begin
    if (n_inputs_q == '0) begin
      cnt = rcs_pkg::CountW'(1);
    end else if (n_inputs_q > rcs_pkg::CountW'(rcs_pkg::EffLim)) begin
      cnt = rcs_pkg::CountW'(rcs_pkg::EffLim);
    end else begin
      cnt = n_inputs_q;
    end
    if (in_i.target_input == '0) begin
      sel = rcs_pkg::SelW'(1);
    end else if (in_i.target_input > cnt) begin
      sel = cnt;
    end else begin
      sel = in_i.target_input;
    end
    sel_m1 = rcs_pkg::IdxW'(sel - rcs_pkg::SelW'(1));
    target = {sel_m1, {rcs_pkg::FracW{1'b0}}};
  end

  // Ramp toward the target without overshoot
  always_comb begin
    pos_up   = {{(rcs_pkg::StepW + 1 - rcs_pkg::PosW){1'b0}}, pos_q}
               + {1'b0, glide_step_q};
    diff     = pos_q - target;
    pos_ramp = pos_q;
    if (pos_q < target) begin
      if (pos_up > {{(rcs_pkg::StepW + 1 - rcs_pkg::PosW){1'b0}}, target}) begin
        pos_ramp = target;
      end else begin
        pos_ramp = pos_up[rcs_pkg::PosW-1:0];
      end
    end else if (pos_q > target) begin
      if ({{(rcs_pkg::StepW - rcs_pkg::PosW){1'b0}}, diff} < glide_step_q) begin
        pos_ramp = target;
      end else begin
        pos_ramp = pos_q - glide_step_q[rcs_pkg::PosW-1:0];
      end
    end
    pos_d = in_i.frame_start ? pos_ramp : pos_q;
  end

  // Blend pair and weights; partner past the last input drops out
  always_comb begin
    idx_a      = pos_d[rcs_pkg::PosW-1:rcs_pkg::FracW];
    idx_b_wide = {1'b0, idx_a} + (rcs_pkg::IdxW + 1)'(1);
    if (idx_b_wide >= cnt) begin
      idx_b = idx_a;
      frac  = '0;
    end else begin
      idx_b = idx_b_wide[rcs_pkg::IdxW-1:0];
      frac  = pos_d[rcs_pkg::FracW-1:0];
    end
    job_o.sample_a = in_i.present_mask[idx_a] ? smp[idx_a] : '0;
    job_o.sample_b = in_i.present_mask[idx_b] ? smp[idx_b] : '0;
    job_o.weight_a = (rcs_pkg::FracW + 1)'(1 << rcs_pkg::FracW) - {1'b0, frac};
    job_o.weight_b = frac;
    job_o.position = pos_d;
  end

  // Config registers and fade position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_inputs_q   <= rcs_pkg::CountW'(rcs_pkg::CountReset);
      glide_step_q <= rcs_pkg::StepW'(rcs_pkg::StepReset);
      pos_q        <= '0;
    end else begin
      if (cfg_i.valid) begin
        if (cfg_i.addr == rcs_pkg::CfgInputCount) begin
          n_inputs_q <= cfg_i.data[rcs_pkg::CountW-1:0];
        end else if (cfg_i.addr == rcs_pkg::CfgRampStep) begin
          glide_step_q <= cfg_i.data;
        end
      end
      if (acc) begin
        pos_q <= pos_d;
      end
    end
  end

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= rcs_pkg::PosW'(rcs_pkg::PosMax))
    else $error("fade position beyond last input");

  a_pos_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(acc && in_i.frame_start) |=> $stable(pos_q))
    else $error("fade position moved without frame start");

endmodule

`default_nettype wire

// File: rtl/core/rcs_queue.sv
// ----------------------------------------------------------------------------
// rcs_queue
// Short FIFO of mix jobs between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module rcs_queue #(
  parameter int DEPTH = rcs_pkg::QueueDepth
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire rcs_pkg::mix_job_t job_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output logic                   valid_o,
  output rcs_pkg::mix_job_t      job_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  rcs_pkg::mix_job_t mem_q [DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q;
  logic              do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (!push_i && do_pop) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || do_pop))
    else $error("push into full queue");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(DEPTH))
    else $error("queue count beyond depth");

endmodule

`default_nettype wire

// File: rtl/core/rcs_back.sv
// ----------------------------------------------------------------------------
// rcs_back
// Weights the two picked samples (multiply stage), sums and floors them into
// the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rcs_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  input  wire rcs_pkg::mix_job_t job_i,
  output logic                   pop_o,
  rcs_out_if.source              out_o
);

  localparam int ProdW = rcs_pkg::SampleW + rcs_pkg::FracW + 2;

  logic                        v1_q, v2_q;
  logic                        s1_ready, s2_ready;
  logic signed [ProdW-1:0]     prod_a_q, prod_b_q, prod_a_d, prod_b_d;
  logic [rcs_pkg::PosW-1:0]    pos1_q, pos2_q;
  logic signed [ProdW:0]       sum;
  logic signed [rcs_pkg::SampleW-1:0] mixed_q;

  assign s2_ready = !v2_q || out_o.ready;
  assign s1_ready = !v1_q || s2_ready;
  assign pop_o    = valid_i && s1_ready;

  // Weighted products
  assign prod_a_d = $signed(job_i.sample_a) * $signed({1'b0, job_i.weight_a});
  assign prod_b_d = $signed(job_i.sample_b) * $signed({2'b00, job_i.weight_b});

  // Sum; dropping the fraction bits floors toward minus infinity
  assign sum = (ProdW + 1)'(prod_a_q) + (ProdW + 1)'(prod_b_q);

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      prod_a_q <= prod_a_d;
      prod_b_q <= prod_b_d;
      pos1_q   <= job_i.position;
    end
    if (v1_q && s2_ready) begin
      mixed_q <= sum[rcs_pkg::FracW +: rcs_pkg::SampleW];
      pos2_q  <= pos1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        v1_q <= valid_i;
      end
      if (s2_ready) begin
        v2_q <= v1_q;
      end
    end
  end

  assign out_o.valid        = v2_q;
  assign out_o.mixed_sample = mixed_q;
  assign out_o.position     = pos2_q;

  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && !s2_ready) |=> (v1_q && $stable(prod_a_q) && $stable(pos1_q)))
    else $error("multiply stage lost an item under stall");

endmodule

`default_nettype wire

// File: rtl/core/ramped_crossfade_selector_top.sv
// ----------------------------------------------------------------------------
// ramped_crossfade_selector_top
// Audio input selector that glides between inputs with a linear crossfade.
//
//   channel  dir  handshake      payload
//   in_i     in   valid/ready    sample_0..7, present_mask, target_input,
//                                frame_start
//   out_o    out  valid/ready    mixed_sample, position
//   cfg_i    in   valid/ready    addr (0 inputs in use, 1 glide step), data
//
// One item per cycle sustained while out_o.ready stays high; a result passes
// through the queue entry, multiply stage and output register after acceptance.
// The fade position is updated at accept time in the front, so items never
// wait on each other. Reset: position 0, two inputs in use, glide step 68.
// in_i.ready drops only when the queue is full; cfg_i is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module ramped_crossfade_selector_top #(
  parameter int QUEUE_DEPTH = rcs_pkg::QueueDepth
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rcs_in_if.sink    in_i,
  rcs_out_if.source out_o,
  rcs_cfg_if.sink   cfg_i
);

  logic              push, full, q_valid, pop;
  rcs_pkg::mix_job_t push_job, q_job;

  rcs_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .cfg_i  (cfg_i),
    .full_i (full),
    .push_o (push),
    .job_o  (push_job)
  );

  rcs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .job_o   (q_job)
  );

  rcs_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .job_i   (q_job),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire
